FILE: design/stt_pkg.sv
// ----------------------------------------------------------------------------
// Source text tokenizer package
// Scanner states, token kinds, error codes, keyword table and result record.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

   localparam int KEYWORD_BYTES = 8;
   localparam int KW_COUNT      = 29;
   localparam int KIND_W        = 6;
   localparam int START_W       = 24;
   localparam int LEN_W         = 9;
   localparam int LINE_W        = 20;
   localparam int ERR_W         = 3;

   localparam logic [LINE_W-1:0] LINE_TOP = '1;

   typedef enum logic [4:0] {
      S_START     = 5'd0,
      S_MINUS     = 5'd1,
      S_COLON     = 5'd2,
      S_LT        = 5'd3,
      S_GT        = 5'd4,
      S_EQ        = 5'd5,
      S_IDENT     = 5'd6,
      S_NUM       = 5'd7,
      S_NUM_EXP   = 5'd8,
      S_CHAR_OPEN = 5'd9,
      S_CHAR_BODY = 5'd10,
      S_STR       = 5'd11,
      S_LCOM      = 5'd12,
      S_BCOM      = 5'd13,
      S_BCOM_BAR  = 5'd14
   } scan_state_type;

   typedef enum logic [1:0] {
      ACT_KEEP = 2'd0,
      ACT_DONE = 2'd1,
      ACT_BACK = 2'd2,
      ACT_FAIL = 2'd3
   } act_type;

   localparam logic [KIND_W-1:0] K_IDENT   = 6'd29;
   localparam logic [KIND_W-1:0] K_COMMENT = 6'd30;
   localparam logic [KIND_W-1:0] K_CHARLIT = 6'd31;
   localparam logic [KIND_W-1:0] K_STRLIT  = 6'd32;
   localparam logic [KIND_W-1:0] K_NUMLIT  = 6'd33;
   localparam logic [KIND_W-1:0] K_ADD     = 6'd34;
   localparam logic [KIND_W-1:0] K_SUB     = 6'd35;
   localparam logic [KIND_W-1:0] K_MUL     = 6'd36;
   localparam logic [KIND_W-1:0] K_DIV     = 6'd37;
   localparam logic [KIND_W-1:0] K_LESS    = 6'd38;
   localparam logic [KIND_W-1:0] K_LESS_EQ = 6'd39;
   localparam logic [KIND_W-1:0] K_MORE    = 6'd40;
   localparam logic [KIND_W-1:0] K_MORE_EQ = 6'd41;
   localparam logic [KIND_W-1:0] K_EQUAL   = 6'd42;
   localparam logic [KIND_W-1:0] K_BIND    = 6'd43;
   localparam logic [KIND_W-1:0] K_SEP     = 6'd44;
   localparam logic [KIND_W-1:0] K_COL     = 6'd45;
   localparam logic [KIND_W-1:0] K_COL2    = 6'd46;
   localparam logic [KIND_W-1:0] K_OPAREN  = 6'd47;
   localparam logic [KIND_W-1:0] K_CPAREN  = 6'd48;
   localparam logic [KIND_W-1:0] K_OBRACK  = 6'd49;
   localparam logic [KIND_W-1:0] K_CBRACK  = 6'd50;
   localparam logic [KIND_W-1:0] K_OBRACE  = 6'd51;
   localparam logic [KIND_W-1:0] K_CBRACE  = 6'd52;
   localparam logic [KIND_W-1:0] K_RARROW  = 6'd53;
   localparam logic [KIND_W-1:0] K_REM     = 6'd54;
   localparam logic [KIND_W-1:0] K_DOT     = 6'd55;
   localparam logic [KIND_W-1:0] K_UPDATE  = 6'd56;
   localparam logic [KIND_W-1:0] K_ERR     = 6'd57;
   localparam logic [KIND_W-1:0] K_EOP     = 6'd58;

   localparam logic [ERR_W-1:0] E_NONE    = 3'd0;
   localparam logic [ERR_W-1:0] E_CHAR    = 3'd1;
   localparam logic [ERR_W-1:0] E_STRING  = 3'd2;
   localparam logic [ERR_W-1:0] E_COMMENT = 3'd3;
   localparam logic [ERR_W-1:0] E_LONG    = 3'd4;

   localparam logic [7:0] CH_NL    = 8'd10;
   localparam logic [7:0] CH_BAR   = 8'h7C;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_QUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOT = 8'h22;

   localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
      64'("Any"), 64'("Number"), 64'("String"), 64'("Boolean"), 64'("Nothing"),
      64'("Function"), 64'("true"), 64'("false"), 64'("fun"), 64'("end"),
      64'("if"), 64'("else"), 64'("var"), 64'("block"), 64'("nothing"),
      64'("when"), 64'("lam"), 64'("shadow"), 64'("list"), 64'("array"),
      64'("empty"), 64'("rec"), 64'("for"), 64'("each"), 64'("is"),
      64'("not"), 64'("and"), 64'("or"), 64'("include")
   };

   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd3, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd4, 4'd5, 4'd3, 4'd3,
      4'd2, 4'd4, 4'd3, 4'd5, 4'd7, 4'd4, 4'd3, 4'd6, 4'd4, 4'd5,
      4'd5, 4'd3, 4'd3, 4'd4, 4'd2, 4'd3, 4'd3, 4'd2, 4'd7
   };

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [START_W-1:0] start;
      logic [LEN_W-1:0]   len;
      logic [LINE_W-1:0]  line;
      logic [ERR_W-1:0]   err;
      logic               last;
   } tok_type;

   // first text byte goes to the lowest byte lane
   function automatic logic [63:0] kw_pack(input logic [63:0] s, input logic [3:0] n);
      logic [63:0] o;
      int          src;
      o = '0;
      for (int j = 0; j < KEYWORD_BYTES; j++) begin
         src = int'(n) - 1 - j;
         if (src >= 0) begin
            o[8*j +: 8] = s[8*src +: 8];
         end
      end
      return o;
   endfunction

   function automatic logic [LINE_W-1:0] line_inc(input logic [LINE_W-1:0] l);
      return (l == LINE_TOP) ? l : l + 1'b1;
   endfunction

endpackage

`default_nettype wire

FILE: design/stt_kw_match.sv
// ----------------------------------------------------------------------------
// Keyword matcher
// Compares the identifier window and length against the keyword table.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_kw_match #(
   parameter int CNT_W = 9
) (
   input  wire logic [63:0]              window,
   input  wire logic [CNT_W-1:0]         count,
   output      logic [stt_pkg::KIND_W-1:0] kind
);
   import stt_pkg::*;

   always_comb begin
      kind = K_IDENT;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (count == CNT_W'(KW_LEN[k]) && window == kw_pack(KW_TEXT[k], KW_LEN[k])) begin
            kind = KIND_W'(k);
         end
      end
   end

endmodule

`default_nettype wire

FILE: design/stt_scan_step.sv
// ----------------------------------------------------------------------------
// Scanner step
// One DFA transition with rollback, flush and end-of-program for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_scan_step #(
   parameter int MAX_TOKEN_BYTES = 511,
   parameter int OFFSET_BITS     = 24,
   parameter int CNT_W           = 9
) (
   input  wire stt_pkg::scan_state_type   st,
   input  wire logic [OFFSET_BITS-1:0]    pos,
   input  wire logic [OFFSET_BITS-1:0]    tstart,
   input  wire logic [CNT_W-1:0]          cnt,
   input  wire logic [stt_pkg::LINE_W-1:0] line,
   input  wire logic [63:0]               kw,
   input  wire logic                      halted,
   input  wire logic [7:0]                c,
   input  wire logic                      eot,
   output      stt_pkg::scan_state_type   st_in,
   output      logic [OFFSET_BITS-1:0]    pos_in,
   output      logic [OFFSET_BITS-1:0]    tstart_in,
   output      logic [CNT_W-1:0]          cnt_in,
   output      logic [stt_pkg::LINE_W-1:0] line_in,
   output      logic [63:0]               kw_in,
   output      logic                      halted_in,
   output      stt_pkg::tok_type          res [3],
   output      logic [1:0]                res_n
);
   import stt_pkg::*;

   logic              is_alpha, is_num, is_idch;
   logic              fs_emit, fs_begin, fs_bump;
   logic [KIND_W-1:0] fs_kind;
   scan_state_type    fs_state;

   logic [KIND_W-1:0] cur_kw_kind, fl_kw_kind;

   scan_state_type     t_st;
   logic [OFFSET_BITS-1:0] t_tstart;
   logic [CNT_W-1:0]   t_cnt;
   logic [LINE_W-1:0]  t_line;
   logic [63:0]        t_kw;
   logic               t_halt;
   tok_type            t_r [2];
   logic [1:0]         t_n;

   act_type            act;
   logic [KIND_W-1:0]  kind;
   logic [ERR_W-1:0]   err;
   scan_state_type     nxt;

   assign is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   assign is_num   = (c >= "0" && c <= "9");
   assign is_idch  = is_alpha || is_num || c == "-";

   stt_kw_match #(.CNT_W(CNT_W)) u_kw_cur (.window(kw),   .count(cnt),   .kind(cur_kw_kind));
   stt_kw_match #(.CNT_W(CNT_W)) u_kw_fl  (.window(t_kw), .count(t_cnt), .kind(fl_kw_kind));

   always_comb begin
      fs_emit  = 1'b0;
      fs_begin = 1'b0;
      fs_bump  = 1'b0;
      fs_kind  = K_ADD;
      fs_state = S_START;
      case (c)
         "+": begin fs_emit = 1'b1; fs_kind = K_ADD; end
         "/": begin fs_emit = 1'b1; fs_kind = K_DIV; end
         "*": begin fs_emit = 1'b1; fs_kind = K_MUL; end
         ",": begin fs_emit = 1'b1; fs_kind = K_SEP; end
         "(": begin fs_emit = 1'b1; fs_kind = K_OPAREN; end
         ")": begin fs_emit = 1'b1; fs_kind = K_CPAREN; end
         "[": begin fs_emit = 1'b1; fs_kind = K_OBRACK; end
         "]": begin fs_emit = 1'b1; fs_kind = K_CBRACK; end
         "{": begin fs_emit = 1'b1; fs_kind = K_OBRACE; end
         "}": begin fs_emit = 1'b1; fs_kind = K_CBRACE; end
         "%": begin fs_emit = 1'b1; fs_kind = K_REM; end
         ".": begin fs_emit = 1'b1; fs_kind = K_DOT; end
         "-": begin fs_begin = 1'b1; fs_state = S_MINUS; end
         ":": begin fs_begin = 1'b1; fs_state = S_COLON; end
         "<": begin fs_begin = 1'b1; fs_state = S_LT; end
         ">": begin fs_begin = 1'b1; fs_state = S_GT; end
         "=": begin fs_begin = 1'b1; fs_state = S_EQ; end
         CH_HASH:  begin fs_begin = 1'b1; fs_state = S_LCOM; end
         CH_QUOTE: begin fs_begin = 1'b1; fs_state = S_CHAR_OPEN; end
         CH_DQUOT: begin fs_begin = 1'b1; fs_state = S_STR; end
         default: begin
            if (is_alpha) begin
               fs_begin = 1'b1;
               fs_state = S_IDENT;
            end else if (is_num) begin
               fs_begin = 1'b1;
               fs_state = S_NUM;
            end else if (c == CH_NL) begin
               fs_bump = 1'b1;
            end
         end
      endcase
   end

   always_comb begin
      act  = ACT_KEEP;
      kind = K_IDENT;
      err  = E_NONE;
      nxt  = st;
      case (st)
         S_MINUS: begin
            if (c == ">") begin act = ACT_DONE; kind = K_RARROW; end
            else if (is_num) nxt = S_NUM;
            else begin act = ACT_BACK; kind = K_SUB; end
         end
         S_COLON: begin
            if (c == ":") begin act = ACT_DONE; kind = K_COL2; end
            else if (c == "=") begin act = ACT_DONE; kind = K_UPDATE; end
            else begin act = ACT_BACK; kind = K_COL; end
         end
         S_LT: begin
            if (c == "=") begin act = ACT_DONE; kind = K_LESS_EQ; end
            else begin act = ACT_BACK; kind = K_LESS; end
         end
         S_GT: begin
            if (c == "=") begin act = ACT_DONE; kind = K_MORE_EQ; end
            else begin act = ACT_BACK; kind = K_MORE; end
         end
         S_EQ: begin
            if (c == "=") begin act = ACT_DONE; kind = K_EQUAL; end
            else begin act = ACT_BACK; kind = K_BIND; end
         end
         S_IDENT: begin
            if (!is_idch) begin act = ACT_BACK; kind = cur_kw_kind; end
         end
         S_NUM: begin
            if (c == "e") nxt = S_NUM_EXP;
            else if (!is_num) begin act = ACT_BACK; kind = K_NUMLIT; end
         end
         S_NUM_EXP: begin
            if (!is_num) begin act = ACT_BACK; kind = K_NUMLIT; end
         end
         S_CHAR_OPEN: begin
            if (c == CH_QUOTE) begin act = ACT_DONE; kind = K_CHARLIT; end
            else nxt = S_CHAR_BODY;
         end
         S_CHAR_BODY: begin
            if (c == CH_QUOTE) begin act = ACT_DONE; kind = K_CHARLIT; end
            else begin act = ACT_FAIL; err = E_CHAR; end
         end
         S_STR: begin
            if (c == CH_DQUOT) begin act = ACT_DONE; kind = K_STRLIT; end
            else if (c == CH_NL) begin act = ACT_FAIL; err = E_STRING; end
         end
         S_LCOM: begin
            if (c == CH_NL) begin act = ACT_BACK; kind = K_COMMENT; end
            else if (c == CH_BAR) nxt = S_BCOM;
         end
         S_BCOM: begin
            if (eot) begin act = ACT_FAIL; err = E_COMMENT; end
            else if (c == CH_BAR) nxt = S_BCOM_BAR;
         end
         S_BCOM_BAR: begin
            if (c == CH_HASH) begin act = ACT_DONE; kind = K_COMMENT; end
            else if (c != CH_BAR) nxt = S_BCOM;
         end
         default: nxt = S_START;
      endcase
   end

   // take the byte
   always_comb begin
      t_st     = st;
      t_tstart = tstart;
      t_cnt    = cnt;
      t_line   = line;
      t_kw     = kw;
      t_halt   = 1'b0;
      t_n      = 2'd0;
      t_r[0]   = '0;
      t_r[1]   = '0;
      if (st == S_START || act == ACT_BACK) begin
         if (st != S_START) begin
            t_r[0] = '{kind, START_W'(tstart), LEN_W'(cnt), line, E_NONE, 1'b0};
            t_n    = 2'd1;
            t_st   = S_START;
         end
         if (fs_emit) begin
            t_r[t_n[0]] = '{fs_kind, START_W'(pos), LEN_W'(1), line, E_NONE, 1'b0};
            t_n         = t_n + 2'd1;
         end else if (fs_begin) begin
            t_st     = fs_state;
            t_tstart = pos;
            t_cnt    = CNT_W'(1);
            t_kw     = 64'(c);
         end else if (fs_bump) begin
            t_line = line_inc(line);
         end
      end else if (act == ACT_FAIL) begin
         t_halt = 1'b1;
         t_r[0] = '{K_ERR, START_W'(tstart), LEN_W'(cnt + 1'b1), line, err, 1'b0};
         t_n    = 2'd1;
      end else if (cnt >= CNT_W'(MAX_TOKEN_BYTES)) begin
         t_halt = 1'b1;
         t_r[0] = '{K_ERR, START_W'(tstart), LEN_W'(cnt), line, E_LONG, 1'b0};
         t_n    = 2'd1;
      end else begin
         if (cnt < CNT_W'(KEYWORD_BYTES)) begin
            t_kw[8*cnt[2:0] +: 8] = c;
         end
         t_cnt = cnt + 1'b1;
         if (act == ACT_DONE) begin
            t_st   = S_START;
            t_r[0] = '{kind, START_W'(tstart), LEN_W'(t_cnt), line, E_NONE, 1'b0};
            t_n    = 2'd1;
         end else begin
            t_st = nxt;
            if (c == CH_NL) t_line = line_inc(line);
         end
      end
   end

   // flush, end of program, restart
   always_comb begin
      logic [KIND_W-1:0] fk;
      logic [ERR_W-1:0]  fe;
      logic              h;
      logic [1:0]        n;
      st_in     = t_st;
      pos_in    = pos + 1'b1;
      tstart_in = t_tstart;
      cnt_in    = t_cnt;
      line_in   = t_line;
      kw_in     = t_kw;
      halted_in = t_halt;
      res[0]    = t_r[0];
      res[1]    = t_r[1];
      res[2]    = '0;
      n         = t_n;
      h         = t_halt;
      fk        = K_ERR;
      fe        = E_NONE;
      case (t_st)
         S_MINUS:                  fk = K_SUB;
         S_COLON:                  fk = K_COL;
         S_LT:                     fk = K_LESS;
         S_GT:                     fk = K_MORE;
         S_EQ:                     fk = K_BIND;
         S_IDENT:                  fk = fl_kw_kind;
         S_NUM, S_NUM_EXP:         fk = K_NUMLIT;
         S_LCOM:                   fk = K_COMMENT;
         S_CHAR_OPEN, S_CHAR_BODY: fe = E_CHAR;
         S_STR:                    fe = E_STRING;
         default:                  fe = E_COMMENT;
      endcase
      if (halted) begin
         st_in     = st;
         pos_in    = pos;
         tstart_in = tstart;
         cnt_in    = cnt;
         line_in   = line;
         kw_in     = kw;
         halted_in = 1'b1;
         n         = 2'd0;
      end else if (eot) begin
         if (!h && t_st != S_START) begin
            res[n] = '{fk, START_W'(t_tstart), LEN_W'(t_cnt), t_line, fe, 1'b0};
            n      = n + 2'd1;
            if (fe != E_NONE) h = 1'b1;
         end
         if (!h) begin
            res[n] = '{K_EOP, START_W'(pos_in), LEN_W'(0), line_inc(t_line), E_NONE, 1'b0};
            n      = n + 2'd1;
         end
      end
      if (eot) begin
         st_in     = S_START;
         pos_in    = '0;
         tstart_in = '0;
         cnt_in    = '0;
         line_in   = LINE_W'(1);
         kw_in     = '0;
         halted_in = 1'b0;
      end
      if (n != 2'd0) res[n - 2'd1].last = 1'b1;
      res_n = n;
   end

endmodule

`default_nettype wire

FILE: design/source_text_tokenizer.sv
// ----------------------------------------------------------------------------
// Source text tokenizer
// DFA lexical scanner: source bytes in, tokens out.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one source byte per request, req_end_of_text on the last
//   byte of a text. rsp_ carries tokens: kind, start offset, length, line,
//   error code, and last_of_run on the final token caused by one byte.
//   A byte may cause zero to three tokens.
//   Latency: a byte's first token is shown the cycle after the byte is taken.
//   Throughput: one byte per cycle while each byte yields at most one token
//   and rsp_stall is low; extra tokens hold the input while they wait in the
//   three-entry token buffer, draining one token per cycle unless stalled.
//   req_stall is high while more than one buffered token waits, or one waits
//   and rsp_stall is high; a stalled token holds on rsp_.
//   After a token with an error, bytes are dropped up to the marked byte.
//   Reset (synchronous) returns the scanner to the start state at offset 0,
//   line 1, and empties the token buffer. After each marked byte the scanner
//   state returns to the same values.
// ----------------------------------------------------------------------------
`default_nettype none

module source_text_tokenizer #(
   parameter int MAX_TOKEN_BYTES = 511,
   parameter int OFFSET_BITS     = 24
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [7:0]  req_source_byte,
   input  wire logic        req_end_of_text,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [5:0]  rsp_token_kind,
   output      logic [23:0] rsp_start_offset,
   output      logic [8:0]  rsp_token_length,
   output      logic [19:0] rsp_line_number,
   output      logic [2:0]  rsp_error_code,
   output      logic        rsp_last_of_run
);
   import stt_pkg::*;

   localparam int CNT_W = $clog2(MAX_TOKEN_BYTES + 2);

   scan_state_type         st_ff, st_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [OFFSET_BITS-1:0] tstart_ff, tstart_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [LINE_W-1:0]      line_ff, line_in;
   logic [63:0]            kw_ff, kw_in;
   logic                   halted_ff, halted_in;

   tok_type    res [3];
   logic [1:0] res_n;
   tok_type    buf_ff [3];
   tok_type    buf_in [3];
   logic [1:0] buf_n_ff, buf_n_in;
   logic       accept, pop;

   stt_scan_step #(
      .MAX_TOKEN_BYTES(MAX_TOKEN_BYTES),
      .OFFSET_BITS(OFFSET_BITS),
      .CNT_W(CNT_W)
   ) u_step (
      .st(st_ff), .pos(pos_ff), .tstart(tstart_ff), .cnt(cnt_ff), .line(line_ff),
      .kw(kw_ff), .halted(halted_ff), .c(req_source_byte), .eot(req_end_of_text),
      .st_in(st_in), .pos_in(pos_in), .tstart_in(tstart_in), .cnt_in(cnt_in),
      .line_in(line_in), .kw_in(kw_in), .halted_in(halted_in),
      .res(res), .res_n(res_n)
   );

   assign pop       = rsp_valid && !rsp_stall;
   assign req_stall = !(buf_n_ff == 2'd0 || (buf_n_ff == 2'd1 && !rsp_stall));
   assign accept    = req_valid && !req_stall;

   always_comb begin
      buf_in   = buf_ff;
      buf_n_in = buf_n_ff;
      if (accept) begin
         buf_in   = res;
         buf_n_in = res_n;
      end else if (pop) begin
         buf_in[0] = buf_ff[1];
         buf_in[1] = buf_ff[2];
         buf_n_in  = buf_n_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= S_START;
         pos_ff    <= '0;
         tstart_ff <= '0;
         cnt_ff    <= '0;
         line_ff   <= LINE_W'(1);
         kw_ff     <= '0;
         halted_ff <= 1'b0;
         buf_n_ff  <= 2'd0;
      end else begin
         if (accept) begin
            st_ff     <= st_in;
            pos_ff    <= pos_in;
            tstart_ff <= tstart_in;
            cnt_ff    <= cnt_in;
            line_ff   <= line_in;
            kw_ff     <= kw_in;
            halted_ff <= halted_in;
         end
         buf_n_ff <= buf_n_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

   assign rsp_valid        = buf_n_ff != 2'd0;
   assign rsp_token_kind   = buf_ff[0].kind;
   assign rsp_start_offset = buf_ff[0].start;
   assign rsp_token_length = buf_ff[0].len;
   assign rsp_line_number  = buf_ff[0].line;
   assign rsp_error_code   = buf_ff[0].err;
   assign rsp_last_of_run  = buf_ff[0].last;

   a_no_accept_backlog: assert property (@(posedge clock) disable iff (reset)
      !(accept && buf_n_ff > 2'd1))
      else $error("request taken with tokens still queued");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("token shown after reset");

   a_last_is_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_of_run) |-> buf_n_ff == 2'd1)
      else $error("last_of_run flag not on final queued token");

endmodule

`default_nettype wire
